// ===== hw/rtl/tarpid_pkg.sv =====
// Shared types and constants for the three-axis rate PID block.
// Holds the controller command struct, step and state codes, and the fixed-point constants.
// No dependencies.
package tarpid_pkg;

	// Axis count and index width of the command bus
	localparam int unsigned AXES_DEF = 3;
	localparam int          AXIS_W   = 2;

	// Field and register widths
	localparam int REG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int RATE_W    = 16;
	localparam int ACCEL_W   = 24;
	localparam int TORQUE_W  = 24;
	localparam int DT_W      = 16;
	localparam int SAT_W     = 6;

	// Datapath widths
	localparam int ACC_W   = 40;
	localparam int TERM_W  = 38;
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 29;
	localparam int PROD_W  = 61;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FF   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;

	// Rate scale: R = radians(400) in Q.10, and floor(2^42 / R^2) for the reciprocal divide
	localparam logic [15:0]           R_Q10       = 16'd7149;
	localparam longint unsigned       R_SQ_L      = 64'd7149 * 64'd7149;
	localparam int                    RECIP_SHIFT = 26;
	localparam longint unsigned       RECIP_K_L   = (64'd1 << (RECIP_SHIFT + 16)) / R_SQ_L;
	localparam logic [16:0]           RECIP_K     = 17'(RECIP_K_L);
	localparam logic [25:0]           R_SQ        = 26'(R_SQ_L);
	localparam logic [16:0]           F_ONE       = 17'd65536;

	// Torque saturation bounds, Q3.20
	localparam logic [TORQUE_W-1:0] TORQUE_MAX = 24'h7FFFFF;
	localparam logic [TORQUE_W-1:0] TORQUE_MIN = 24'h800000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	// Per-axis schedule: each MUL step issues one multiply; later steps consume the previous product
	typedef enum logic [3:0] {
		STEP_ERR,
		STEP_MUL_P,
		STEP_MUL_D,
		STEP_MUL_FF,
		STEP_MUL_SQ,
		STEP_MUL_K,
		STEP_MUL_QD,
		STEP_MUL_DM,
		STEP_MUL_FG,
		STEP_MUL_FIN,
		STEP_ROUND,
		STEP_UPDATE
	} step_t;

	typedef struct packed {
		logic              capture;
		logic              run;
		step_t             step;
		logic [AXIS_W-1:0] axis;
		logic              load_out;
	} cmd_t;

	// Pick one 16-bit field of a packed per-axis register
	function automatic logic [15:0] field16(input logic [REG_W-1:0] r, input logic [AXIS_W-1:0] a);
		logic [15:0] f;
		case (a)
			2'd0:    f = r[15:0];
			2'd1:    f = r[31:16];
			default: f = r[47:32];
		endcase
		return f;
	endfunction

endpackage

// ===== hw/rtl/tarpid_ctrl.sv =====
// Controller of the three-axis rate PID: sequences steps and axes, owns the handshakes.
// Depends on tarpid_pkg.
module tarpid_ctrl #(
	parameter int unsigned AXES = tarpid_pkg::AXES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	output logic               result_valid,
	input  logic               result_stall,
	output tarpid_pkg::cmd_t   cmd
);
	import tarpid_pkg::*;

	localparam int              AW        = (AXES > 1) ? $clog2(AXES) : 1;
	localparam logic [AW-1:0]   AXIS_LAST = AW'(AXES - 1);

	state_t        state_q, state_d;
	step_t         step_q, step_d;
	logic [AW-1:0] axis_q, axis_d;
	logic          out_valid_q;
	logic          out_free;
	logic          last_step;

	// Next state and commands
	always_comb begin
		out_free     = !out_valid_q || !result_stall;
		last_step    = (step_q == STEP_UPDATE) && (axis_q == AXIS_LAST);
		state_d      = state_q;
		step_d       = step_q;
		axis_d       = axis_q;
		cmd.capture  = 1'b0;
		cmd.run      = 1'b0;
		cmd.step     = step_q;
		cmd.axis     = AXIS_W'(axis_q);
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_RUN;
					step_d      = STEP_ERR;
					axis_d      = '0;
				end
			end
			ST_RUN: begin
				cmd.run = 1'b1;
				if (step_q == STEP_UPDATE) begin
					step_d = STEP_ERR;
					if (last_step) begin
						axis_d = '0;
						if (out_free) begin
							cmd.load_out = 1'b1;
							state_d      = ST_IDLE;
						end else begin
							state_d = ST_HOLD;
						end
					end else begin
						axis_d = axis_q + AW'(1);
					end
				end else begin
					step_d = step_t'(step_q + 4'd1);
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State, schedule counters and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_ERR;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			axis_q  <= axis_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

endmodule

// ===== hw/rtl/tarpid_dp.sv =====
// Datapath of the three-axis rate PID: config registers, integrators, one shared multiplier.
// Depends on tarpid_pkg; driven step by step from tarpid_ctrl.
module tarpid_dp #(
	parameter int unsigned AXES = tarpid_pkg::AXES_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  tarpid_pkg::cmd_t                                cmd,
	input  logic                                            cfg_write,
	input  logic [tarpid_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [tarpid_pkg::REG_W-1:0]                    cfg_data,
	input  logic [2:0][tarpid_pkg::RATE_W-1:0]              meas,
	input  logic [2:0][tarpid_pkg::RATE_W-1:0]              target,
	input  logic [2:0][tarpid_pkg::ACCEL_W-1:0]             accel,
	input  logic [tarpid_pkg::DT_W-1:0]                     step_time,
	input  logic                                            on_ground,
	input  logic [tarpid_pkg::SAT_W-1:0]                    saturation_flags,
	output logic [2:0][tarpid_pkg::TORQUE_W-1:0]            torque
);
	import tarpid_pkg::*;

	localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

	// Configuration registers
	logic [REG_W-1:0] gain_p_q, gain_i_q, gain_d_q, gain_ff_q, int_limit_q;

	// Captured item
	logic [RATE_W-1:0]  meas_q   [AXES];
	logic [RATE_W-1:0]  tgt_q    [AXES];
	logic [ACCEL_W-1:0] accin_q  [AXES];
	logic [DT_W-1:0]    dt_q;
	logic               landed_q;
	logic [SAT_W-1:0]   sat_q;

	// Per-axis state and results
	logic signed [TORQUE_W-1:0] integ_q  [AXES];
	logic [TORQUE_W-1:0]        torque_q [AXES];
	logic [TORQUE_W-1:0]        result_q [AXES];

	// Working registers
	logic signed [16:0]       e_q;
	logic [15:0]              m_q;
	logic                     mneg_q;
	logic                     big_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [TERM_W-1:0]        tm_q;
	logic                     tneg_q;
	logic [25:0]              x_q;
	logic [16:0]              q0_q;
	logic [16:0]              f_q;
	logic [28:0]              dm_q;
	logic [TORQUE_W-1:0]      inc_q;
	logic [PROD_W-1:0]        prod_q;

	// Combinational values
	logic [AW-1:0]              ax;
	logic [RATE_W-1:0]          meas_c, tgt_c, tgt_abs;
	logic [ACCEL_W-1:0]         accin_c, acc_abs;
	logic signed [TORQUE_W-1:0] integ_c;
	logic [15:0]                gp_c, gi_c, gd_c, gff_c, il_c;
	logic                       e_neg, acc_neg, sat_pos, sat_neg, clip_zero;
	logic [15:0]                e_abs;
	logic [ACC_W-1:0]           rnd40;
	logic [TERM_W-1:0]          term_c;
	logic signed [ACC_W-1:0]    acc_next;
	logic [TORQUE_W-1:0]        acc_sat;
	logic [42:0]                rem_lhs;
	logic [16:0]                q_corr, f_c;
	logic [PROD_W:0]            rnd62;
	logic [TORQUE_W-1:0]        inc_c;
	logic [TORQUE_W-1:0]        lim_c;
	logic signed [25:0]         inc_s, lim_s, ni;
	logic [TORQUE_W-1:0]        upd_c;
	logic [MUL_A_W-1:0]         mul_a;
	logic [MUL_B_W-1:0]         mul_b;

	// Select the current axis operands
	always_comb begin
		ax      = cmd.axis[AW-1:0];
		meas_c  = meas_q[ax];
		tgt_c   = tgt_q[ax];
		accin_c = accin_q[ax];
		integ_c = integ_q[ax];
		gp_c    = field16(gain_p_q, cmd.axis);
		gi_c    = field16(gain_i_q, cmd.axis);
		gd_c    = field16(gain_d_q, cmd.axis);
		gff_c   = field16(gain_ff_q, cmd.axis);
		il_c    = field16(int_limit_q, cmd.axis);
		sat_pos = sat_q[3'(ax)];
		sat_neg = sat_q[3'(ax) + 3'd3];
	end

	// Magnitudes, error clipping, rounding of the torque terms, accumulation and saturation
	always_comb begin
		e_neg     = e_q[16];
		e_abs     = 16'(e_neg ? -e_q : e_q);
		acc_neg   = accin_c[ACCEL_W-1];
		acc_abs   = acc_neg ? ACCEL_W'(-accin_c) : accin_c;
		tgt_abs   = tgt_c[RATE_W-1] ? RATE_W'(-tgt_c) : tgt_c;
		clip_zero = (e_q == '0) || (sat_pos && !e_neg) || (sat_neg && e_neg);
		rnd40     = prod_q[ACC_W-1:0] + ACC_W'(2);
		term_c    = rnd40[ACC_W-1:2];
		acc_next  = tneg_q ? acc_q - $signed({2'b00, tm_q}) : acc_q + $signed({2'b00, tm_q});
		if (acc_q > $signed(ACC_W'(TORQUE_MAX))) begin
			acc_sat = TORQUE_MAX;
		end else if (acc_q < -$signed(ACC_W'(TORQUE_MIN))) begin
			acc_sat = TORQUE_MIN;
		end else begin
			acc_sat = acc_q[TORQUE_W-1:0];
		end
	end

	// Anti-windup scale factor and integrator update
	always_comb begin
		rem_lhs = {1'b0, x_q, 16'h0000};
		q_corr  = (rem_lhs >= prod_q[42:0]) ? q0_q + 17'd1 : q0_q;
		f_c     = (big_q || (q_corr >= F_ONE)) ? 17'd0 : F_ONE - q_corr;
		rnd62   = {1'b0, prod_q} + (62'd1 << 37);
		inc_c   = rnd62[61:38];
		lim_c   = il_c[15] ? TORQUE_MAX : {il_c[14:0], 8'h00};
		inc_s   = $signed({2'b00, inc_q});
		lim_s   = $signed({2'b00, lim_c});
		ni      = mneg_q ? 26'(integ_c) - inc_s : 26'(integ_c) + inc_s;
		if (ni > lim_s) begin
			upd_c = lim_c;
		end else if (ni < -lim_s) begin
			upd_c = TORQUE_W'(-lim_s);
		end else begin
			upd_c = ni[TORQUE_W-1:0];
		end
	end

	// Route operands to the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.step)
			STEP_MUL_P: begin
				mul_a = MUL_A_W'(gp_c);
				mul_b = MUL_B_W'(e_abs);
			end
			STEP_MUL_D: begin
				mul_a = MUL_A_W'(gd_c);
				mul_b = MUL_B_W'(acc_abs);
			end
			STEP_MUL_FF: begin
				mul_a = MUL_A_W'(gff_c);
				mul_b = MUL_B_W'(tgt_abs);
			end
			STEP_MUL_SQ: begin
				mul_a = MUL_A_W'(m_q[12:0]);
				mul_b = MUL_B_W'(m_q[12:0]);
			end
			STEP_MUL_K: begin
				mul_a = MUL_A_W'(prod_q[25:0]);
				mul_b = MUL_B_W'(RECIP_K);
			end
			STEP_MUL_QD: begin
				mul_a = MUL_A_W'(R_SQ);
				mul_b = MUL_B_W'(prod_q[42:26] + 17'd1);
			end
			STEP_MUL_DM: begin
				mul_a = MUL_A_W'(dt_q);
				mul_b = MUL_B_W'(m_q[12:0]);
			end
			STEP_MUL_FG: begin
				mul_a = MUL_A_W'(f_q);
				mul_b = MUL_B_W'(gi_c);
			end
			STEP_MUL_FIN: begin
				mul_a = prod_q[MUL_A_W-1:0];
				mul_b = dm_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Write configuration registers and integrators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			gain_ff_q   <= '0;
			int_limit_q <= '0;
			for (int k = 0; k < AXES; k++) begin
				integ_q[k] <= '0;
			end
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_GAIN_P:    gain_p_q    <= cfg_data;
					REG_GAIN_I:    gain_i_q    <= cfg_data;
					REG_GAIN_D:    gain_d_q    <= cfg_data;
					REG_GAIN_FF:   gain_ff_q   <= cfg_data;
					REG_INT_LIMIT: int_limit_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.run && (cmd.step == STEP_UPDATE) && !landed_q) begin
				integ_q[ax] <= $signed(upd_c);
			end
		end
	end

	// Capture the item, run the per-axis steps, load the result
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.capture) begin
			for (int k = 0; k < AXES; k++) begin
				meas_q[k]  <= meas[k];
				tgt_q[k]   <= target[k];
				accin_q[k] <= accel[k];
			end
			dt_q     <= step_time;
			landed_q <= on_ground;
			sat_q    <= saturation_flags;
		end
		if (cmd.run) begin
			case (cmd.step)
				STEP_ERR: begin
					e_q <= $signed({tgt_c[RATE_W-1], tgt_c}) - $signed({meas_c[RATE_W-1], meas_c});
				end
				STEP_MUL_P: begin
					m_q    <= clip_zero ? 16'd0 : e_abs;
					mneg_q <= e_neg && !clip_zero;
					acc_q  <= ACC_W'(integ_c);
				end
				STEP_MUL_D: begin
					tm_q   <= term_c;
					tneg_q <= e_neg;
					big_q  <= (m_q >= R_Q10);
				end
				STEP_MUL_FF: begin
					acc_q  <= acc_next;
					tm_q   <= term_c;
					tneg_q <= !acc_neg;
				end
				STEP_MUL_SQ: begin
					acc_q  <= acc_next;
					tm_q   <= term_c;
					tneg_q <= tgt_c[RATE_W-1];
				end
				STEP_MUL_K: begin
					acc_q <= acc_next;
					x_q   <= prod_q[25:0];
				end
				STEP_MUL_QD: begin
					q0_q         <= prod_q[42:26];
					torque_q[ax] <= acc_sat;
				end
				STEP_MUL_DM: begin
					f_q <= f_c;
				end
				STEP_MUL_FG: begin
					dm_q <= prod_q[28:0];
				end
				STEP_ROUND: begin
					inc_q <= inc_c;
				end
				default: ;
			endcase
		end
		if (cmd.load_out) begin
			for (int k = 0; k < AXES; k++) begin
				result_q[k] <= torque_q[k];
			end
		end
	end

	// Drive torque fields; axes outside the configured count read zero
	for (genvar k = 0; k < 3; k++) begin : g_out
		if (k < AXES) begin : g_on
			assign torque[k] = result_q[k];
		end else begin : g_off
			assign torque[k] = '0;
		end
	end

endmodule

// ===== hw/rtl/three_axis_rate_pid.sv =====
// Three-axis angular-rate PID with integrator anti-windup.
// result_valid rises once the last axis is updated and the output register is free.
// The input stalls until then, set by the single shared 32x29 multiplier,
// which forms the products of each axis in sequence.
// A finished result waits in an output register while the next item is accepted.
// Reset (arst_n low) clears integrators, gains and limits to zero and empties the output.
module three_axis_rate_pid #(
	parameter int unsigned AXES = tarpid_pkg::AXES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [tarpid_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tarpid_pkg::REG_W-1:0]            cfg_data,
	input  logic                                    item_valid,
	output logic                                    item_stall,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    meas_roll,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    meas_pitch,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    meas_yaw,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    target_roll,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    target_pitch,
	input  logic signed [tarpid_pkg::RATE_W-1:0]    target_yaw,
	input  logic signed [tarpid_pkg::ACCEL_W-1:0]   accel_roll,
	input  logic signed [tarpid_pkg::ACCEL_W-1:0]   accel_pitch,
	input  logic signed [tarpid_pkg::ACCEL_W-1:0]   accel_yaw,
	input  logic [tarpid_pkg::DT_W-1:0]             step_time,
	input  logic                                    on_ground,
	input  logic [tarpid_pkg::SAT_W-1:0]            saturation_flags,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_roll,
	output logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_pitch,
	output logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_yaw
);
	import tarpid_pkg::*;

	cmd_t                        cmd;
	logic [2:0][RATE_W-1:0]      meas_v;
	logic [2:0][RATE_W-1:0]      target_v;
	logic [2:0][ACCEL_W-1:0]     accel_v;
	logic [2:0][TORQUE_W-1:0]    torque_v;

	// Gather per-axis fields, roll first
	assign meas_v   = {meas_yaw, meas_pitch, meas_roll};
	assign target_v = {target_yaw, target_pitch, target_roll};
	assign accel_v  = {accel_yaw, accel_pitch, accel_roll};

	tarpid_ctrl #(
		.AXES (AXES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	tarpid_dp #(
		.AXES (AXES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.meas             (meas_v),
		.target           (target_v),
		.accel            (accel_v),
		.step_time        (step_time),
		.on_ground        (on_ground),
		.saturation_flags (saturation_flags),
		.torque           (torque_v)
	);

	assign torque_roll  = $signed(torque_v[0]);
	assign torque_pitch = $signed(torque_v[1]);
	assign torque_yaw   = $signed(torque_v[2]);

endmodule

// ===== hw/rtl/tarpid_chk.sv =====
// Port-level checks for three_axis_rate_pid, bound to the top level.
// Depends on tarpid_pkg.
module tarpid_chk #(
	parameter int unsigned AXES = tarpid_pkg::AXES_DEF
) (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    item_valid,
	input logic                                    item_stall,
	input logic                                    result_valid,
	input logic                                    result_stall,
	input logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_roll,
	input logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_pitch,
	input logic signed [tarpid_pkg::TORQUE_W-1:0]  torque_yaw
);
	import tarpid_pkg::*;

	// A taken item keeps the input side busy
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after an item was taken");

	// No result can be finished in the cycle right after taking an item
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> !$rose(result_valid))
		else $error("result appeared right after an item was taken");

	// Publishing a result frees the input side
	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !item_stall)
		else $error("input still stalled when a result was published");

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(torque_roll)
			&& $stable(torque_pitch) && $stable(torque_yaw))
		else $error("stalled result changed");

	// Unused axes report zero torque
	a_unused_axis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (AXES > 2 || torque_yaw == '0) && (AXES > 1 || torque_pitch == '0))
		else $error("unused axis carries torque");

endmodule

bind three_axis_rate_pid tarpid_chk #(.AXES(AXES)) u_tarpid_chk (.*);
